// File: hdl/lcte_pkg.sv
package lcte_pkg;

   // request operation codes
   typedef enum logic {
      OP_SET = 1'b0,
      OP_GET = 1'b1
   } op_type;

   // register map, index of each register
   localparam int unsigned REG_CAPACITY = 0;

   localparam int unsigned CAP_BITS     = 5;
   localparam int unsigned CAP_RESET    = 16;
   localparam int unsigned TIME_BITS    = 32;
   localparam int unsigned TTL_BITS     = 16;
   localparam int unsigned EXPIRY_BITS  = 33;
   localparam int unsigned EXP_CNT_BITS = 5;
   localparam int unsigned CSR_ADDR_BITS = 2;
   localparam int unsigned CSR_DATA_BITS = 32;

endpackage

// File: hdl/lru_cache_with_ttl_expiry_top.sv
// LRU key/value cache with time-to-live expiry. Requests enter a two-entry
// queue; the engine then handles each request in two steps: one to drop every
// entry whose expiry is at or before the request time and recompact the
// recency ranks, one for the parallel key lookup, eviction and insert.
// The engine finishes one request before it takes the next, and its second
// step waits until the previous result is popped. The capacity register (reset 16,
// zero acts as one, values above ENTRIES act as ENTRIES) must be written only
// while the block is idle; the block itself does not enforce this.
module lru_cache_with_ttl_expiry_top
   import lcte_pkg::*;
#(
   parameter int unsigned ENTRIES    = 16,
   parameter int unsigned KEY_BITS   = 64,
   parameter int unsigned VALUE_BITS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic                     req_func,
   input  logic [KEY_BITS-1:0]      req_key,
   input  logic [VALUE_BITS-1:0]    req_value,
   input  logic [TTL_BITS-1:0]      req_ttl,
   input  logic [TIME_BITS-1:0]     req_now,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic                     rsp_found,
   output logic [VALUE_BITS-1:0]    rsp_read_value,
   output logic                     rsp_evicted,
   output logic [KEY_BITS-1:0]      rsp_evicted_key,
   output logic [EXP_CNT_BITS-1:0]  rsp_expired_count,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   logic                  head_valid, head_pop;
   op_type                head_op;
   logic [KEY_BITS-1:0]   head_key;
   logic [VALUE_BITS-1:0] head_value;
   logic [TTL_BITS-1:0]   head_ttl;
   logic [TIME_BITS-1:0]  head_now;
   logic [CAP_BITS-1:0]   cap_ff;
   logic                  cap_sel;

   // configuration register
   assign csr_pready = 1'b1;
   assign cap_sel    = (csr_paddr == CSR_ADDR_BITS'(REG_CAPACITY * 4));
   assign csr_prdata = cap_sel ? CSR_DATA_BITS'(cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_BITS'(CAP_RESET);
      end else if (csr_psel && csr_penable && csr_pwrite && cap_sel) begin
         cap_ff <= csr_pwdata[CAP_BITS-1:0];
      end
   end

   lcte_front #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_func   (req_func),
      .req_key    (req_key),
      .req_value  (req_value),
      .req_ttl    (req_ttl),
      .req_now    (req_now),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .head_op    (head_op),
      .head_key   (head_key),
      .head_value (head_value),
      .head_ttl   (head_ttl),
      .head_now   (head_now)
   );

   lcte_back #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .capacity          (cap_ff),
      .head_valid        (head_valid),
      .head_pop          (head_pop),
      .head_op           (head_op),
      .head_key          (head_key),
      .head_value        (head_value),
      .head_ttl          (head_ttl),
      .head_now          (head_now),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_found         (rsp_found),
      .rsp_read_value    (rsp_read_value),
      .rsp_evicted       (rsp_evicted),
      .rsp_evicted_key   (rsp_evicted_key),
      .rsp_expired_count (rsp_expired_count)
   );

endmodule

// File: hdl/lcte_front.sv
module lcte_front
   import lcte_pkg::*;
#(
   parameter int unsigned KEY_BITS   = 64,
   parameter int unsigned VALUE_BITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_func,
   input  logic [KEY_BITS-1:0]   req_key,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic [TTL_BITS-1:0]   req_ttl,
   input  logic [TIME_BITS-1:0]  req_now,
   output logic                  head_valid,
   input  logic                  head_pop,
   output op_type                head_op,
   output logic [KEY_BITS-1:0]   head_key,
   output logic [VALUE_BITS-1:0] head_value,
   output logic [TTL_BITS-1:0]   head_ttl,
   output logic [TIME_BITS-1:0]  head_now
);

   op_type                op_q    [2];
   logic [KEY_BITS-1:0]   key_q   [2];
   logic [VALUE_BITS-1:0] value_q [2];
   logic [TTL_BITS-1:0]   ttl_q   [2];
   logic [TIME_BITS-1:0]  now_q   [2];

   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok, pop_ok;

   assign req_full   = (cnt_ff == 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign push_ok    = req_push && !req_full;
   assign pop_ok     = head_pop && head_valid;

   // head of the request queue
   assign head_op    = op_q[rd_ptr_ff];
   assign head_key   = key_q[rd_ptr_ff];
   assign head_value = value_q[rd_ptr_ff];
   assign head_ttl   = ttl_q[rd_ptr_ff];
   assign head_now   = now_q[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = push_ok ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop_ok && !push_ok) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // request storage, operation decoded on entry
   always_ff @(posedge clock) begin
      if (push_ok) begin
         op_q[wr_ptr_ff]    <= req_func ? OP_GET : OP_SET;
         key_q[wr_ptr_ff]   <= req_key;
         value_q[wr_ptr_ff] <= req_value;
         ttl_q[wr_ptr_ff]   <= req_ttl;
         now_q[wr_ptr_ff]   <= req_now;
      end
   end

endmodule

// File: hdl/lcte_back.sv
module lcte_back
   import lcte_pkg::*;
#(
   parameter int unsigned ENTRIES    = 16,
   parameter int unsigned KEY_BITS   = 64,
   parameter int unsigned VALUE_BITS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [CAP_BITS-1:0]     capacity,
   input  logic                    head_valid,
   output logic                    head_pop,
   input  op_type                  head_op,
   input  logic [KEY_BITS-1:0]     head_key,
   input  logic [VALUE_BITS-1:0]   head_value,
   input  logic [TTL_BITS-1:0]     head_ttl,
   input  logic [TIME_BITS-1:0]    head_now,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic                    rsp_found,
   output logic [VALUE_BITS-1:0]   rsp_read_value,
   output logic                    rsp_evicted,
   output logic [KEY_BITS-1:0]     rsp_evicted_key,
   output logic [EXP_CNT_BITS-1:0] rsp_expired_count
);

   localparam int unsigned RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CW = $clog2(ENTRIES + 1);
   localparam int unsigned LW = (CW > CAP_BITS) ? CW : CAP_BITS;

   typedef enum logic {
      ST_SWEEP,
      ST_COMMIT
   } state_type;

   // entry storage
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [KEY_BITS-1:0]   key_ff   [ENTRIES];
   logic [VALUE_BITS-1:0] val_ff   [ENTRIES];
   logic [EXPIRY_BITS-1:0] exp_ff  [ENTRIES];
   logic [RW-1:0]         rank_ff  [ENTRIES];
   logic [RW-1:0]         rank_in  [ENTRIES];
   logic [ENTRIES-1:0]    wr_en;
   logic [ENTRIES-1:0]    wr_key;

   // request held through the commit cycle
   state_type               state_ff;
   op_type                  op_ff;
   logic [KEY_BITS-1:0]     ckey_ff;
   logic [VALUE_BITS-1:0]   cval_ff;
   logic [EXPIRY_BITS-1:0]  cexp_ff;
   logic [EXP_CNT_BITS-1:0] exp_cnt_ff;

   // result register
   logic                    rvalid_ff;
   logic                    rfound_ff;
   logic [VALUE_BITS-1:0]   rval_ff;
   logic                    rev_ff;
   logic [KEY_BITS-1:0]     revk_ff;
   logic [EXP_CNT_BITS-1:0] rexp_ff;

   logic [ENTRIES-1:0]   expd;
   logic [CW+EXP_CNT_BITS-1:0] exp_sum;
   logic [RW-1:0]        fresh [ENTRIES];
   logic [CW-1:0]        dec;

   logic [CW-1:0]        cnt;
   logic [CW-1:0]        cnt_m1;
   logic [LW-1:0]        limit;
   logic [ENTRIES-1:0]   hit, oldest, v2, free_oh;
   logic                 hit_any, evict, commit;
   logic [RW-1:0]        hit_rank;
   logic [VALUE_BITS-1:0] hit_val;
   logic [KEY_BITS-1:0]  old_key;

   assign head_pop = (state_ff == ST_SWEEP) && head_valid;
   assign commit   = (state_ff == ST_COMMIT) && (!rvalid_ff || rsp_pop);

   // expiry sweep and rank compaction on the incoming request
   always_comb begin
      exp_sum = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         expd[i] = valid_ff[i] && (exp_ff[i] <= {1'b0, head_now});
         exp_sum = exp_sum + (CW+EXP_CNT_BITS)'(expd[i]);
      end
      for (int i = 0; i < ENTRIES; i++) begin
         dec = '0;
         for (int j = 0; j < ENTRIES; j++) begin
            if (expd[j] && (rank_ff[j] < rank_ff[i])) begin
               dec = dec + CW'(1);
            end
         end
         fresh[i] = rank_ff[i] - dec[RW-1:0];
      end
   end

   // lookup, victim choice and free slot
   always_comb begin
      cnt      = '0;
      hit_rank = '0;
      hit_val  = '0;
      old_key  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         cnt = cnt + CW'(valid_ff[i]);
      end
      cnt_m1 = cnt - CW'(1);
      for (int i = 0; i < ENTRIES; i++) begin
         hit[i]    = valid_ff[i] && (key_ff[i] == ckey_ff);
         oldest[i] = valid_ff[i] && (rank_ff[i] == cnt_m1[RW-1:0]);
         if (hit[i]) begin
            hit_rank = hit_rank | rank_ff[i];
            hit_val  = hit_val | val_ff[i];
         end
         if (oldest[i]) begin
            old_key = old_key | key_ff[i];
         end
      end
      hit_any = |hit;
      priority if (capacity == '0) begin
         limit = LW'(1);
      end else if (LW'(capacity) > LW'(ENTRIES)) begin
         limit = LW'(ENTRIES);
      end else begin
         limit = LW'(capacity);
      end
      evict   = (op_ff == OP_SET) && !hit_any && (LW'(cnt) >= limit);
      v2      = evict ? (valid_ff & ~oldest) : valid_ff;
      free_oh = ~v2 & (v2 + ENTRIES'(1));
   end

   // next entry state
   always_comb begin
      valid_in = valid_ff;
      wr_en    = '0;
      wr_key   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (head_pop) begin
         valid_in = valid_ff & ~expd;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_in[i] = fresh[i];
         end
      end else if (commit) begin
         if (hit_any) begin
            // move the hit entry to the front
            for (int i = 0; i < ENTRIES; i++) begin
               if (hit[i]) begin
                  rank_in[i] = '0;
               end else if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
                  rank_in[i] = rank_ff[i] + RW'(1);
               end
            end
            if (op_ff == OP_SET) begin
               wr_en = hit;
            end
         end else if (op_ff == OP_SET) begin
            // insert into the first free slot, all others age by one
            valid_in = v2 | free_oh;
            wr_en    = free_oh;
            wr_key   = free_oh;
            for (int i = 0; i < ENTRIES; i++) begin
               if (free_oh[i]) begin
                  rank_in[i] = '0;
               end else if (v2[i]) begin
                  rank_in[i] = rank_ff[i] + RW'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // entry payload
   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         rank_ff[i] <= rank_in[i];
         if (wr_en[i]) begin
            val_ff[i] <= cval_ff;
            exp_ff[i] <= cexp_ff;
         end
         if (wr_key[i]) begin
            key_ff[i] <= ckey_ff;
         end
      end
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_SWEEP;
         rvalid_ff <= 1'b0;
      end else begin
         if (rsp_pop && rvalid_ff) begin
            rvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_SWEEP: begin
               if (head_valid) begin
                  state_ff <= ST_COMMIT;
               end
            end
            ST_COMMIT: begin
               if (commit) begin
                  state_ff  <= ST_SWEEP;
                  rvalid_ff <= 1'b1;
               end
            end
            default: state_ff <= ST_SWEEP;
         endcase
      end
   end

   // request capture and result payload
   always_ff @(posedge clock) begin
      if (head_pop) begin
         op_ff      <= head_op;
         ckey_ff    <= head_key;
         cval_ff    <= head_value;
         cexp_ff    <= {1'b0, head_now} + EXPIRY_BITS'(head_ttl);
         exp_cnt_ff <= exp_sum[EXP_CNT_BITS-1:0];
      end
      if (commit) begin
         rfound_ff <= hit_any;
         rval_ff   <= (hit_any && (op_ff == OP_GET)) ? hit_val : '0;
         rev_ff    <= evict;
         revk_ff   <= evict ? old_key : '0;
         rexp_ff   <= exp_cnt_ff;
      end
   end

   assign rsp_empty         = !rvalid_ff;
   assign rsp_found         = rfound_ff;
   assign rsp_read_value    = rval_ff;
   assign rsp_evicted       = rev_ff;
   assign rsp_evicted_key   = revk_ff;
   assign rsp_expired_count = rexp_ff;

endmodule

// File: tb/lru_cache_with_ttl_expiry_top_tb.sv
`timescale 1ns / 1ps

module lru_cache_with_ttl_expiry_top_tb;
   import lcte_pkg::*;

   localparam int N_ENT = 16;
   localparam int PHASE_ITEMS = 235;

   typedef struct packed {
      logic                    found;
      logic [63:0]             read_value;
      logic                    evicted;
      logic [63:0]             evicted_key;
      logic [EXP_CNT_BITS-1:0] expired_count;
   } lookup_t;

   typedef struct {
      op_type      func;
      logic [63:0] key;
      logic [63:0] value;
      logic [15:0] ttl;
      logic [31:0] now;
      bit          known;
      lookup_t     want;
   } req_row_t;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_push = 1'b0;
   logic                     req_full;
   logic                     req_func = 1'b0;
   logic [63:0]              req_key = '0;
   logic [63:0]              req_value = '0;
   logic [TTL_BITS-1:0]      req_ttl = '0;
   logic [TIME_BITS-1:0]     req_now = '0;
   logic                     rsp_empty;
   logic                     rsp_pop = 1'b0;
   logic                     rsp_found;
   logic [63:0]              rsp_read_value;
   logic                     rsp_evicted;
   logic [63:0]              rsp_evicted_key;
   logic [EXP_CNT_BITS-1:0]  rsp_expired_count;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   lru_cache_with_ttl_expiry_top dut (.*);

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow cache
   logic        sh_valid [N_ENT];
   logic [63:0] sh_key [N_ENT];
   logic [63:0] sh_value [N_ENT];
   logic [32:0] sh_expiry [N_ENT];
   int          sh_rank [N_ENT];
   logic [4:0]  sh_capacity;

   lookup_t     lookup_q[$];
   int          mismatches = 0;
   bit          calm = 0;
   req_row_t    rows[$];

   // model of one request, updates the shadow cache
   function automatic lookup_t cache_access(op_type f, logic [63:0] k, logic [63:0] v,
                                            logic [15:0] ttl, logic [31:0] now);
      lookup_t r;
      int fresh [N_ENT];
      int cnt, hit, lim, oldest, slot;
      r = '0;
      cnt = 0;
      hit = -1;
      slot = -1;
      oldest = -1;
      // expiry sweep
      for (int i = 0; i < N_ENT; i++) begin
         if (sh_valid[i] && sh_expiry[i] <= {1'b0, now}) begin
            sh_valid[i] = 1'b0;
            r.expired_count = r.expired_count + 1'b1;
         end
      end
      // recompact ranks
      for (int i = 0; i < N_ENT; i++) begin
         fresh[i] = 0;
         if (sh_valid[i])
            for (int j = 0; j < N_ENT; j++)
               if (j != i && sh_valid[j] && sh_rank[j] < sh_rank[i]) fresh[i]++;
      end
      for (int i = 0; i < N_ENT; i++) if (sh_valid[i]) sh_rank[i] = fresh[i];
      for (int i = 0; i < N_ENT; i++) begin
         if (sh_valid[i]) begin
            cnt++;
            if (sh_key[i] == k) hit = i;
         end
      end
      lim = (sh_capacity == 0) ? 1 : int'(sh_capacity);
      if (lim > N_ENT) lim = N_ENT;
      if (hit >= 0) begin
         r.found = 1'b1;
         if (f == OP_GET) begin
            r.read_value = sh_value[hit];
         end else begin
            sh_value[hit] = v;
            sh_expiry[hit] = {1'b0, now} + ttl;
         end
         for (int j = 0; j < N_ENT; j++)
            if (j != hit && sh_valid[j] && sh_rank[j] < sh_rank[hit]) sh_rank[j]++;
         sh_rank[hit] = 0;
      end else if (f == OP_SET) begin
         // evict the least recently used entry when at the limit
         if (cnt >= lim) begin
            for (int i = 0; i < N_ENT; i++)
               if (sh_valid[i] && (oldest < 0 || sh_rank[i] > sh_rank[oldest])) oldest = i;
            if (oldest >= 0) begin
               r.evicted = 1'b1;
               r.evicted_key = sh_key[oldest];
               sh_valid[oldest] = 1'b0;
            end
         end
         for (int i = N_ENT - 1; i >= 0; i--) if (!sh_valid[i]) slot = i;
         if (slot >= 0) begin
            for (int i = 0; i < N_ENT; i++) if (sh_valid[i]) sh_rank[i]++;
            sh_valid[slot] = 1'b1;
            sh_key[slot] = k;
            sh_value[slot] = v;
            sh_expiry[slot] = {1'b0, now} + ttl;
            sh_rank[slot] = 0;
         end
      end
      return r;
   endfunction

   // register write, setup then access
   task automatic csr_write(logic [CSR_ADDR_BITS-1:0] addr, logic [31:0] data);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr = addr;
      csr_pwdata = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      if (addr == CSR_ADDR_BITS'(REG_CAPACITY * 4)) sh_capacity = data[4:0];
   endtask

   // stop sending, hold off until every request has answered, then let the engine drain
   task automatic wait_idle();
      @(negedge clock);
      req_push = 1'b0;
      while (lookup_q.size() != 0) @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   // push one request, holding push high across back-to-back requests
   task automatic push_request(req_row_t row);
      lookup_t p;
      if (!calm) begin
         while ($urandom_range(99) < 27) begin
            @(negedge clock);
            req_push = 1'b0;
         end
      end
      @(negedge clock);
      req_push = 1'b1;
      req_func = row.func;
      req_key = row.key;
      req_value = row.value;
      req_ttl = row.ttl;
      req_now = row.now;
      do @(posedge clock); while (req_full);
      p = cache_access(row.func, row.key, row.value, row.ttl, row.now);
      lookup_q.push_back(row.known ? row.want : p);
   endtask

   function automatic req_row_t mk_row(op_type f, logic [63:0] k, logic [63:0] v,
                                      logic [15:0] ttl, logic [31:0] now, bit known,
                                      lookup_t want);
      req_row_t r;
      r.func = f;
      r.key = k;
      r.value = v;
      r.ttl = ttl;
      r.now = now;
      r.known = known;
      r.want = want;
      return r;
   endfunction

   // response side: random pop (always in the calm phase), compare at the edge
   always @(negedge clock) begin
      if (reset) rsp_pop = 1'b0;
      else rsp_pop = calm ? 1'b1 : ($urandom_range(99) >= 27);
   end

   always @(posedge clock) begin
      lookup_t got, w;
      if (!reset && rsp_pop && !rsp_empty) begin
         got = {rsp_found, rsp_read_value, rsp_evicted, rsp_evicted_key, rsp_expired_count};
         if (lookup_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
         end else begin
            w = lookup_q.pop_front();
            if (got.found !== w.found || got.read_value !== w.read_value ||
                got.evicted !== w.evicted || got.evicted_key !== w.evicted_key ||
                got.expired_count !== w.expired_count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: found %b/%b rd %h/%h ev %b/%b evk %h/%h exp %0d/%0d",
                           w.found, got.found, w.read_value, got.read_value, w.evicted,
                           got.evicted, w.evicted_key, got.evicted_key, w.expired_count,
                           got.expired_count);
            end
         end
      end
   end

   // main stimulus
   initial begin
      logic [63:0] pool [24];
      logic [4:0]  caps [8];
      logic [31:0] cur;
      logic [63:0] k;
      logic [15:0] ttl;
      lookup_t     z;
      lookup_t     w;
      int          sel;
      caps = '{5'd16, 5'd1, 5'd3, 5'd0, 5'd31, 5'd8, 5'd2, 5'd16};
      z = '0;
      sh_capacity = CAP_RESET[4:0];
      for (int i = 0; i < N_ENT; i++) begin
         sh_valid[i] = 1'b0;
         sh_key[i] = '0;
         sh_value[i] = '0;
         sh_expiry[i] = '0;
         sh_rank[i] = 0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      rows.push_back(mk_row(OP_GET, '0, '1, 16'hffff, 32'd0, 1, z));
      rows.push_back(mk_row(OP_SET, '1, '1, 16'hffff, 32'd0, 1, z));
      w = z; w.found = 1'b1; w.read_value = '1;
      rows.push_back(mk_row(OP_GET, '1, '0, '0, 32'd0, 1, w));
      rows.push_back(mk_row(OP_SET, '0, '0, 16'd0, 32'd1, 1, z));
      w = z; w.expired_count = 5'd1;
      rows.push_back(mk_row(OP_GET, '0, '0, '0, 32'd1, 1, w));
      w = z; w.found = 1'b1;
      rows.push_back(mk_row(OP_SET, '1, 64'h123, 16'd10, 32'd2, 1, w));
      for (int i = 2; i < 6; i++)
         rows.push_back(mk_row(OP_SET, 64'(i), 64'(i * 7), 16'd100, 32'd3, 0, z));
      rows.push_back(mk_row(OP_GET, '1, '0, '0, 32'd4, 0, z));
      rows.push_back(mk_row(OP_GET, 64'd3, '1, '1, 32'd5, 0, z));
      rows.push_back(mk_row(OP_SET, 64'd9, 64'h5a5a, 16'd1, 32'd50, 0, z));
      rows.push_back(mk_row(OP_GET, '1, '0, '0, 32'hffff_ffff, 0, z));
      rows.push_back(mk_row(OP_SET, 64'ha5a5_a5a5_a5a5_a5a5, 64'h8000_0000_0000_0001,
                            16'hffff, 32'hffff_ffff, 0, z));
      rows.push_back(mk_row(OP_GET, 64'ha5a5_a5a5_a5a5_a5a5, '0, '0, 32'hffff_ffff, 0, z));
      // time going backwards
      rows.push_back(mk_row(OP_GET, 64'ha5a5_a5a5_a5a5_a5a5, '0, '0, 32'd0, 0, z));
      rows.push_back(mk_row(OP_SET, 64'ha5a5_a5a5_a5a5_a5a5, 64'd1, 16'd5, 32'd0, 0, z));
      foreach (rows[i]) push_request(rows[i]);

      // random phases, one capacity setting each
      for (int ph = 0; ph < 8; ph++) begin
         wait_idle();
         csr_write(CSR_ADDR_BITS'(REG_CAPACITY * 4), {27'd0, caps[ph]});
         foreach (pool[i]) pool[i] = {$urandom, $urandom};
         pool[0] = '0;
         pool[1] = '1;
         cur = (ph == 0) ? 32'd100 : (ph == 7) ? 32'hffff_ff00 : $urandom;
         calm = (ph == 5);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // sender waits for the pipeline to empty once
            if (ph == 2 && n == 100) begin
               @(negedge clock);
               req_push = 1'b0;
               while (lookup_q.size() != 0) @(posedge clock);
            end
            sel = $urandom_range(99);
            if (sel < 3) cur = cur - $urandom_range(20);
            else cur = cur + $urandom_range(3);
            k = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                         : pool[$urandom_range(caps[ph] > 3 ? 23 : 5)];
            sel = $urandom_range(99);
            ttl = (sel < 10) ? 16'd0 : (sel < 18) ? 16'hffff :
                  (sel < 25) ? 16'($urandom) : 16'($urandom_range(1, 40));
            push_request(mk_row($urandom_range(1) ? OP_GET : OP_SET, k,
                                {$urandom, $urandom}, ttl, cur, 0, z));
         end
         @(negedge clock);
         req_push = 1'b0;
      end
      calm = 0;

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && lookup_q.size() == 0) begin
         $display("lru_cache_with_ttl_expiry_top test passed");
      end else begin
         $display("lru_cache_with_ttl_expiry_top test failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("lru_cache_with_ttl_expiry_top test failed");
      $finish;
   end

endmodule
